### rtl/core/sxtok_pkg.sv
// ----------------------------------------------------------------------------
// sxtok_pkg: shared types and constants of the s-expression tokenizer
// Token kinds, lexer modes, character codes and the token record that
// travels from the lexer front end through the token queue to the back end.
// ----------------------------------------------------------------------------
package sxtok_pkg;

  // token kinds as seen on the result port
  typedef enum logic [3:0] {
    TOK_LPAREN = 4'd0,
    TOK_RPAREN = 4'd1,
    TOK_PERIOD = 4'd2,
    TOK_QUOTE  = 4'd3,
    TOK_INT    = 4'd4,
    TOK_STRING = 4'd5,
    TOK_SYMBOL = 4'd6,
    TOK_ERROR  = 4'd7,
    TOK_END    = 4'd8
  } tok_kind_e;

  // lexer modes, one-hot
  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_COMMENT = 6'b000010,
    MODE_INT     = 6'b000100,
    MODE_STRING  = 6'b001000,
    MODE_SYMBOL  = 6'b010000,
    MODE_ERROR   = 6'b100000
  } mode_e;

  // character codes
  localparam logic [7:0] ChSemi    = 8'h3B;
  localparam logic [7:0] ChLParen  = 8'h28;
  localparam logic [7:0] ChRParen  = 8'h29;
  localparam logic [7:0] ChPeriod  = 8'h2E;
  localparam logic [7:0] ChQuote   = 8'h27;
  localparam logic [7:0] ChDQuote  = 8'h22;
  localparam logic [7:0] ChNewline = 8'h0A;

  // width of the offset and length fields on the result port
  localparam int unsigned OutBits = 16;

  // one token as delivered
  typedef struct packed {
    tok_kind_e            kind;
    logic [OutBits-1:0]   start;
    logic [OutBits-1:0]   length;
  } token_t;

  // everything one character produces: one token, or two when two is set
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } tok_pair_t;

endpackage

### rtl/core/sxtok_fifo.sv
// ----------------------------------------------------------------------------
// sxtok_fifo: token queue between lexer front end and output back end
// Small register-based first-in first-out queue; the head entry is always
// visible on data_o while empty_o is low.
// ----------------------------------------------------------------------------
module sxtok_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntFull);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // fill count stays within the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntFull)
    else $error("token queue count above depth");

  // a push into an empty queue shows up at the head next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && empty_o) |=> (!empty_o && data_o == $past(data_i)))
    else $error("token queue head does not match first push");

endmodule

### rtl/core/sxtok_front.sv
// ----------------------------------------------------------------------------
// sxtok_front: lexer front end
// Accepts one character per transaction, classifies it against the current
// lexer mode and pushes the one or two tokens it finishes into the queue.
// ----------------------------------------------------------------------------
module sxtok_front import sxtok_pkg::*; #(
  parameter int unsigned POS_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  logic [7:0] ch_i,
  input  logic      end_of_text_i,
  input  logic      q_full_i,
  output logic      q_push_o,
  output tok_pair_t q_data_o
);

  localparam logic [POS_BITS-1:0] PosMax = '1;

  // result of lexing one character from idle
  typedef struct packed {
    logic       hit;
    tok_kind_e  kind;
    logic       len1;
    mode_e      mode;
    logic       set_org;
    logic [POS_BITS-1:0] org;
  } lex_t;

  mode_e               mode_q, mode_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [POS_BITS-1:0] org_q, org_d;
  logic                acc;
  lex_t                lx;
  logic [POS_BITS-1:0] span_v;
  logic                close_hit;
  tok_kind_e           close_kind;
  logic [POS_BITS-1:0] close_start;
  logic [POS_BITS-1:0] close_len;
  logic                lex_hit;
  tok_kind_e           lex_kind;
  logic                lex_len1;
  token_t              close_tok;
  token_t              lex_tok;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  function automatic logic is_graphic(input logic [7:0] c);
    return (c >= 8'd33) && (c <= 8'd126);
  endfunction

  function automatic logic [OutBits-1:0] clamp_out(input logic [POS_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? '1 : w[OutBits-1:0];
  endfunction

  function automatic lex_t lex_idle(input logic [7:0] c, input logic [POS_BITS-1:0] p);
    lex_t r;
    r.hit     = 1'b0;
    r.kind    = TOK_ERROR;
    r.len1    = 1'b1;
    r.mode    = MODE_IDLE;
    r.set_org = 1'b0;
    r.org     = p;
    if (is_space(c)) begin
      r.mode = MODE_IDLE;
    end else if (c == ChSemi) begin
      r.mode = MODE_COMMENT;
    end else if (c == ChLParen) begin
      r.hit  = 1'b1;
      r.kind = TOK_LPAREN;
    end else if (c == ChRParen) begin
      r.hit  = 1'b1;
      r.kind = TOK_RPAREN;
    end else if (c == ChPeriod) begin
      r.hit  = 1'b1;
      r.kind = TOK_PERIOD;
    end else if (c == ChQuote) begin
      r.hit  = 1'b1;
      r.kind = TOK_QUOTE;
    end else if (is_digit(c)) begin
      r.mode    = MODE_INT;
      r.set_org = 1'b1;
    end else if (c == ChDQuote) begin
      r.mode    = MODE_STRING;
      r.set_org = 1'b1;
      r.org     = (p == PosMax) ? PosMax : p + 1'b1;
    end else if (is_graphic(c)) begin
      r.mode    = MODE_SYMBOL;
      r.set_org = 1'b1;
    end else begin
      r.hit  = 1'b1;
      r.kind = TOK_ERROR;
      r.len1 = 1'b0;
      r.mode = MODE_ERROR;
    end
    return r;
  endfunction

  assign acc    = push_i && !q_full_i;
  assign lx     = lex_idle(ch_i, pos_q);
  assign span_v = (pos_q > org_q) ? pos_q - org_q : '0;

  // mode update and token selection for one character
  always_comb begin
    mode_d      = mode_q;
    pos_d       = pos_q;
    org_d       = org_q;
    close_hit   = 1'b0;
    close_kind  = TOK_ERROR;
    close_start = pos_q;
    close_len   = '0;
    lex_hit     = 1'b0;
    lex_kind    = TOK_ERROR;
    lex_len1    = 1'b0;
    if (end_of_text_i) begin
      // flush pending token, then the end marker
      case (mode_q)
        MODE_INT: begin
          close_hit   = 1'b1;
          close_kind  = TOK_INT;
          close_start = org_q;
          close_len   = span_v;
        end
        MODE_SYMBOL: begin
          close_hit   = 1'b1;
          close_kind  = TOK_SYMBOL;
          close_start = org_q;
          close_len   = span_v;
        end
        MODE_STRING: begin
          close_hit  = 1'b1;
          close_kind = TOK_ERROR;
        end
        default: begin
          close_hit = 1'b0;
        end
      endcase
      lex_hit  = 1'b1;
      lex_kind = TOK_END;
      mode_d   = MODE_IDLE;
      pos_d    = '0;
      org_d    = '0;
    end else begin
      pos_d = (pos_q == PosMax) ? PosMax : pos_q + 1'b1;
      case (mode_q)
        MODE_COMMENT: begin
          if (ch_i == ChNewline) begin
            mode_d = MODE_IDLE;
          end
        end
        MODE_INT: begin
          if (is_digit(ch_i)) begin
            mode_d = MODE_INT;
          end else if (is_space(ch_i) || ch_i == ChLParen || ch_i == ChRParen) begin
            close_hit   = 1'b1;
            close_kind  = TOK_INT;
            close_start = org_q;
            close_len   = span_v;
            lex_hit     = lx.hit;
            lex_kind    = lx.kind;
            lex_len1    = lx.len1;
            mode_d      = lx.mode;
            if (lx.set_org) begin
              org_d = lx.org;
            end
          end else begin
            close_hit  = 1'b1;
            close_kind = TOK_ERROR;
            mode_d     = MODE_ERROR;
          end
        end
        MODE_STRING: begin
          if (ch_i == ChDQuote) begin
            close_hit   = 1'b1;
            close_kind  = TOK_STRING;
            close_start = org_q;
            close_len   = span_v;
            mode_d      = MODE_IDLE;
          end
        end
        MODE_SYMBOL: begin
          if (!(is_graphic(ch_i) && ch_i != ChLParen && ch_i != ChRParen)) begin
            close_hit   = 1'b1;
            close_kind  = TOK_SYMBOL;
            close_start = org_q;
            close_len   = span_v;
            lex_hit     = lx.hit;
            lex_kind    = lx.kind;
            lex_len1    = lx.len1;
            mode_d      = lx.mode;
            if (lx.set_org) begin
              org_d = lx.org;
            end
          end
        end
        MODE_ERROR: begin
          mode_d = MODE_ERROR;
        end
        default: begin
          lex_hit  = lx.hit;
          lex_kind = lx.kind;
          lex_len1 = lx.len1;
          mode_d   = lx.mode;
          if (lx.set_org) begin
            org_d = lx.org;
          end
        end
      endcase
    end
  end

  // pack the finished tokens for the queue
  always_comb begin
    close_tok.kind   = close_kind;
    close_tok.start  = clamp_out(close_start);
    close_tok.length = clamp_out(close_len);
    lex_tok.kind     = lex_kind;
    lex_tok.start    = clamp_out(pos_q);
    lex_tok.length   = lex_len1 ? OutBits'(1) : '0;
    q_data_o.two     = close_hit && lex_hit;
    q_data_o.tok0    = close_hit ? close_tok : lex_tok;
    q_data_o.tok1    = lex_tok;
  end

  assign q_push_o = acc && (close_hit || lex_hit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pos_q  <= '0;
      org_q  <= '0;
    end else if (acc) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      org_q  <= org_d;
    end
  end

  // end of text always returns the lexer to its reset state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && end_of_text_i) |=> (mode_q == MODE_IDLE && pos_q == '0 && org_q == '0))
    else $error("lexer not cleared after end of text");

  // end of text always delivers an end marker as the last token
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && end_of_text_i) |-> (q_push_o && q_data_o.tok1.kind == TOK_END))
    else $error("end of text without end marker");

  // the character offset holds once saturated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !end_of_text_i && pos_q == PosMax) |=> (pos_q == PosMax))
    else $error("character offset wrapped");

endmodule

### rtl/core/sxtok_back.sv
// ----------------------------------------------------------------------------
// sxtok_back: output back end
// Walks the queue head entry token by token, marks the last token of each
// character and retires the entry when its last token is taken.
// ----------------------------------------------------------------------------
module sxtok_back import sxtok_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  tok_pair_t           q_head_i,
  output logic                q_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output logic [3:0]          token_kind_o,
  output logic [OutBits-1:0]  token_start_o,
  output logic [OutBits-1:0]  token_length_o,
  output logic                last_of_run_o
);

  logic   sel_q, sel_d;
  logic   take;
  logic   last;
  token_t cur;

  assign empty_o = q_empty_i;
  assign take    = pop_i && !q_empty_i;
  assign last    = sel_q || !q_head_i.two;
  assign cur     = sel_q ? q_head_i.tok1 : q_head_i.tok0;
  assign q_pop_o = take && last;

  // current token of the head entry
  assign token_kind_o   = cur.kind;
  assign token_start_o  = cur.start;
  assign token_length_o = cur.length;
  assign last_of_run_o  = last;

  // step to the second token or back to the first of the next entry
  always_comb begin
    sel_d = sel_q;
    if (take) begin
      sel_d = !last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

  // second token is only ever selected on a two-token entry at the head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> (!q_empty_i && q_head_i.two))
    else $error("second token selected on a single-token entry");

endmodule

### rtl/core/sexpr_tokenizer.sv
// ----------------------------------------------------------------------------
// sexpr_tokenizer: s-expression lexer, one character per transaction
// Top level: lexer front end, token queue and output back end.
// ----------------------------------------------------------------------------
// Usage
//   Input side is a queue: drive ch_i / end_of_text_i with push; the
//   transaction completes on a clock edge with push high and full low.
//   Result side is a queue: while empty is low the oldest token sits on
//   token_kind_o, token_start_o, token_length_o and last_of_run_o; it is
//   taken on a clock edge with pop high and empty low.
//   Each character gives zero, one or two tokens; last_of_run_o marks the
//   final token of a character. end_of_text_i flushes a pending token,
//   emits the end marker and restarts offsets at zero.
//   With the queue empty, a token is visible the cycle after its character is taken.
//   Throughput: one character per cycle while the token queue has room;
//   the result side drains one token per cycle while pop is high, so a
//   character giving two tokens occupies the output for two pops. The
//   front end's lexer mode register closes the per-character loop.
//   The queue holds QUEUE_DEPTH characters' worth of tokens; when the
//   receiver stalls, full rises once the queue fills and no token is lost.
//   Reset clears the lexer mode, offsets and the queue; no sweep follows.
// ----------------------------------------------------------------------------
module sexpr_tokenizer import sxtok_pkg::*; #(
  parameter int unsigned POS_BITS    = 16,  // 8 to 32
  parameter int unsigned QUEUE_DEPTH = 4    // 2 to 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         ch_i,
  input  logic               end_of_text_i,
  output logic               empty,
  input  logic               pop,
  output logic [3:0]         token_kind_o,
  output logic [OutBits-1:0] token_start_o,
  output logic [OutBits-1:0] token_length_o,
  output logic               last_of_run_o
);

  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  tok_pair_t q_wdata;
  tok_pair_t q_head;

  assign full = q_full;

  // lexer front end
  sxtok_front #(
    .POS_BITS (POS_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .ch_i          (ch_i),
    .end_of_text_i (end_of_text_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  // token queue
  sxtok_fifo #(
    .WIDTH ($bits(tok_pair_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_head),
    .empty_o (q_empty)
  );

  // output back end
  sxtok_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_head_i       (q_head),
    .q_pop_o        (q_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .token_kind_o   (token_kind_o),
    .token_start_o  (token_start_o),
    .token_length_o (token_length_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule
